// ----- rtl/core/jep_pkg.sv -----
// ----------------------------------------------------------------------------
// jep_pkg: shared types and constants of the JPEG end-of-image packetizer
// Holds the result beat layout, kind codes, marker bytes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package jep_pkg;

   // Fixed field widths.
   localparam int BYTE_W  = 8;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 24;

   // Default and reset values of the block length.
   localparam int MAX_BLOCK_DEFAULT = 60;
   localparam logic [SLOT_W-1:0] PKT_SIZE_RESET = 6'd60;
   localparam logic [SLOT_W-1:0] PKT_SIZE_MIN   = 6'd2;

   // Marker bytes.
   localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [BYTE_W-1:0] MARKER_EOI    = 8'hD9;
   localparam logic [BYTE_W-1:0] PAD_BYTE      = 8'h00;

   // Result kinds.
   localparam logic KIND_BLOCK  = 1'b0;
   localparam logic KIND_HEADER = 1'b1;

   // One result beat.
   typedef struct packed {
      logic               item_kind;
      logic [BYTE_W-1:0]  byte_value;
      logic [SLOT_W-1:0]  slot_index;
      logic               first_flag;
      logic               last_flag;
      logic [COUNT_W-1:0] packet_number;
      logic               end_of_run;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/jep_sequencer.sv -----
// ----------------------------------------------------------------------------
// jep_sequencer: packet sequencer
// Produces one result beat per advance: the data byte of an accepted input
// beat, then any zero pad beats and the packet header when a packet closes.
// ----------------------------------------------------------------------------
`default_nettype none

module jep_sequencer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [jep_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                              req_ready,
   input  wire logic [jep_pkg::SLOT_W-1:0]   pkt_size,
   input  wire logic                         load_en,
   output logic                              gen_valid,
   output jep_pkg::result_type               gen_result
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PAD,
      PH_HEAD
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [jep_pkg::SLOT_W-1:0]     fill_pos_ff, fill_pos_in;
   logic                           prev_ff_ff, prev_ff_in;
   logic                           next_first_ff, next_first_in;
   logic [jep_pkg::COUNT_W-1:0]    pkt_count_ff, pkt_count_in;
   logic [jep_pkg::SLOT_W-1:0]     pad_slot_ff, pad_slot_in;
   logic                           eoi_ff, eoi_in;

   logic                           eoi_now;
   logic                           close_now;
   logic [jep_pkg::SLOT_W-1:0]     slot_next;
   logic [jep_pkg::SLOT_W-1:0]     pad_next;
   logic                           advance;

   // Decode of the incoming byte against the current packet.
   assign eoi_now   = (fill_pos_ff != '0) && prev_ff_ff
                      && (req_data_byte == jep_pkg::MARKER_EOI);
   assign close_now = eoi_now || (fill_pos_ff >= pkt_size - 6'd1);
   assign slot_next = fill_pos_ff + 6'd1;
   assign pad_next  = pad_slot_ff + 6'd1;

   assign gen_valid = (phase_ff != PH_IDLE) || req_valid;
   assign req_ready = (phase_ff == PH_IDLE) && load_en;
   assign advance   = gen_valid && load_en;

   // Result beat and next state for the current phase.
   always_comb begin
      phase_in      = phase_ff;
      fill_pos_in   = fill_pos_ff;
      prev_ff_in    = prev_ff_ff;
      next_first_in = next_first_ff;
      pkt_count_in  = pkt_count_ff;
      pad_slot_in   = pad_slot_ff;
      eoi_in        = eoi_ff;

      gen_result               = '0;
      gen_result.item_kind     = jep_pkg::KIND_BLOCK;

      unique case (phase_ff)
         PH_IDLE: begin
            gen_result.byte_value = req_data_byte;
            gen_result.slot_index = fill_pos_ff;
            gen_result.end_of_run = !close_now;
            if (close_now) begin
               fill_pos_in = '0;
               prev_ff_in  = 1'b0;
               eoi_in      = eoi_now;
               pad_slot_in = slot_next;
               if (eoi_now && (slot_next < pkt_size)) begin
                  phase_in = PH_PAD;
               end else begin
                  phase_in = PH_HEAD;
               end
            end else begin
               fill_pos_in = slot_next;
               prev_ff_in  = (req_data_byte == jep_pkg::MARKER_PREFIX);
            end
         end
         PH_PAD: begin
            gen_result.byte_value = jep_pkg::PAD_BYTE;
            gen_result.slot_index = pad_slot_ff;
            pad_slot_in           = pad_next;
            if (pad_next >= pkt_size) begin
               phase_in = PH_HEAD;
            end
         end
         PH_HEAD: begin
            gen_result.item_kind     = jep_pkg::KIND_HEADER;
            gen_result.first_flag    = next_first_ff;
            gen_result.last_flag     = eoi_ff;
            gen_result.packet_number = pkt_count_ff;
            gen_result.end_of_run    = 1'b1;
            pkt_count_in             = pkt_count_ff + 24'd1;
            next_first_in            = eoi_ff;
            phase_in                 = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // State holds; it moves only when a beat goes into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         fill_pos_ff   <= '0;
         prev_ff_ff    <= 1'b0;
         next_first_ff <= 1'b1;
         pkt_count_ff  <= '0;
         pad_slot_ff   <= '0;
         eoi_ff        <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         fill_pos_ff   <= fill_pos_in;
         prev_ff_ff    <= prev_ff_in;
         next_first_ff <= next_first_in;
         pkt_count_ff  <= pkt_count_in;
         pad_slot_ff   <= pad_slot_in;
         eoi_ff        <= eoi_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/jpeg_eoi_packetizer.sv -----
// A result beat appears on the output in the cycle after its source. One input
// beat per cycle is taken mid packet; a closing byte adds a header beat, and
// an end-of-image marker a zero pad beat per slot left, taking no input meanwhile.
// The single result register sets the rate: one beat a cycle unless stalled.
// Reset: synchronous, active high; block length returns to 60, the packet
// count to zero, and the next packet is marked first of an image.
// ----------------------------------------------------------------------------
// jpeg_eoi_packetizer: top level of the JPEG end-of-image packetizer
// Holds the block length register, clamps it, and registers the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_eoi_packetizer #(
   parameter int MAX_BLOCK = jep_pkg::MAX_BLOCK_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Configuration write channel.
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [jep_pkg::SLOT_W-1:0]    csr_block_length,
   // Input channel.
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [jep_pkg::BYTE_W-1:0]    req_data_byte,
   // Result channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_item_kind,
   output logic [jep_pkg::BYTE_W-1:0]         rsp_byte_value,
   output logic [jep_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic                               rsp_first_flag,
   output logic                               rsp_last_flag,
   output logic [jep_pkg::COUNT_W-1:0]        rsp_packet_number,
   output logic                               rsp_end_of_run
);

   localparam logic [jep_pkg::SLOT_W-1:0] MaxLen = jep_pkg::SLOT_W'(MAX_BLOCK);

   logic [jep_pkg::SLOT_W-1:0] pkt_size_ff;
   logic [jep_pkg::SLOT_W-1:0] pkt_size_eff;
   logic                       rsp_valid_ff;
   jep_pkg::result_type        rsp_data_ff;
   logic                       load_en;
   logic                       gen_valid;
   jep_pkg::result_type        gen_result;

   // Block length register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_size_ff <= jep_pkg::PKT_SIZE_RESET;
      end else if (csr_valid) begin
         pkt_size_ff <= csr_block_length;
      end
   end

   // Out-of-range lengths act as the nearest legal one.
   always_comb begin
      if (pkt_size_ff < jep_pkg::PKT_SIZE_MIN) begin
         pkt_size_eff = jep_pkg::PKT_SIZE_MIN;
      end else if (pkt_size_ff > MaxLen) begin
         pkt_size_eff = MaxLen;
      end else begin
         pkt_size_eff = pkt_size_ff;
      end
   end

   // The output register loads when it is empty or its beat is taken.
   assign load_en = !rsp_valid_ff || rsp_ready;

   jep_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_ready     (req_ready),
      .pkt_size      (pkt_size_eff),
      .load_en       (load_en),
      .gen_valid     (gen_valid),
      .gen_result    (gen_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_en) begin
         rsp_valid_ff <= gen_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && gen_valid) begin
         rsp_data_ff <= gen_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_kind     = rsp_data_ff.item_kind;
   assign rsp_byte_value    = rsp_data_ff.byte_value;
   assign rsp_slot_index    = rsp_data_ff.slot_index;
   assign rsp_first_flag    = rsp_data_ff.first_flag;
   assign rsp_last_flag     = rsp_data_ff.last_flag;
   assign rsp_packet_number = rsp_data_ff.packet_number;
   assign rsp_end_of_run    = rsp_data_ff.end_of_run;

endmodule

`default_nettype wire
